// ===== rtl/rtfu_pkg.sv =====
// Shared types, constants and helper functions for the RTC field to
// Unix seconds converter. Has no dependencies; every other file uses it.
package rtfu_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HOUR_24_MODE = 2'd0;
   localparam logic [1:0] CSR_BINARY_MODE  = 2'd1;

   localparam logic [7:0] PM_FLAG_MASK = 8'h80;
   localparam logic [7:0] CENTURY_SCALE = 8'd100;
   localparam logic [7:0] HOURS_HALF_DAY = 8'd12;

   // Days from 0000-03-01 to 1970-01-01 in the March-based calendar.
   localparam logic signed [22:0] EPOCH_SHIFT = 23'sd719468;

   typedef struct packed {
      logic [7:0] hours_raw;
      logic [7:0] minutes_raw;
      logic [7:0] seconds_raw;
      logic [7:0] year_raw;
      logic [7:0] month_raw;
      logic [7:0] day_raw;
      logic [7:0] century_raw;
   } req_word_type;

   typedef struct packed {
      logic signed [38:0] unix_seconds;
      logic               time_valid;
   } rsp_word_type;

   // Decoded and range-checked fields (day check still pending).
   typedef struct packed {
      logic       ok;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [6:0] year;
      logic [6:0] century;
      logic [3:0] month;
      logic [7:0] day;
   } dec_type;

   // Calendar terms: March-based century and year, day of year, time of day.
   typedef struct packed {
      logic              ok;
      logic signed [7:0] cent_adj;
      logic [6:0]        year_adj;
      logic [8:0]        day_of_year;
      logic [16:0]       time_of_day;
   } cal_type;

   // Signed day count since the epoch plus time of day.
   typedef struct packed {
      logic               ok;
      logic signed [22:0] days;
      logic [16:0]        time_of_day;
   } day_type;

   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      bcd_decode = 8'({4'b0, b[7:4]} * 8'd10) + {4'b0, b[3:0]};
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      month_days = len;
   endfunction

   // Day of the March-based year on which the given month starts.
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] start;
      unique case (month)
         4'd3:    start = 9'd0;
         4'd4:    start = 9'd31;
         4'd5:    start = 9'd61;
         4'd6:    start = 9'd92;
         4'd7:    start = 9'd122;
         4'd8:    start = 9'd153;
         4'd9:    start = 9'd184;
         4'd10:   start = 9'd214;
         4'd11:   start = 9'd245;
         4'd12:   start = 9'd275;
         4'd1:    start = 9'd306;
         4'd2:    start = 9'd337;
         default: start = 9'd0;
      endcase
      month_start = start;
   endfunction

endpackage

// ===== rtl/rtfu_decode.sv =====
// First pipeline stage: BCD decode, 12-hour conversion and field range checks.
// Depends on rtfu_pkg.
module rtfu_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  hour_24_mode,
   input  logic                  binary_mode,
   input  logic                  in_valid,
   input  rtfu_pkg::req_word_type in_word,
   output logic                  out_valid,
   output rtfu_pkg::dec_type     out_dec
);

   logic              valid_ff;
   rtfu_pkg::dec_type dec_ff;
   rtfu_pkg::dec_type dec_in;

   logic       pm;
   logic [7:0] hr, hr_fix, mi, se, yr, mo, dy, ce;
   logic       hr_ok;

   always_comb begin
      pm = (in_word.hours_raw & rtfu_pkg::PM_FLAG_MASK) != 8'd0;
      hr = in_word.hours_raw & ~rtfu_pkg::PM_FLAG_MASK;
      mi = in_word.minutes_raw;
      se = in_word.seconds_raw;
      yr = in_word.year_raw;
      mo = in_word.month_raw;
      dy = in_word.day_raw;
      ce = in_word.century_raw;
      if (!binary_mode) begin
         hr = rtfu_pkg::bcd_decode(hr);
         mi = rtfu_pkg::bcd_decode(mi);
         se = rtfu_pkg::bcd_decode(se);
         yr = rtfu_pkg::bcd_decode(yr);
         mo = rtfu_pkg::bcd_decode(mo);
         dy = rtfu_pkg::bcd_decode(dy);
         ce = rtfu_pkg::bcd_decode(ce);
      end

      hr_ok  = 1'b1;
      hr_fix = hr;
      if (!hour_24_mode) begin
         if (hr < 8'd1 || hr > rtfu_pkg::HOURS_HALF_DAY) begin
            hr_ok = 1'b0;
         end else if (hr == rtfu_pkg::HOURS_HALF_DAY) begin
            hr_fix = pm ? rtfu_pkg::HOURS_HALF_DAY : 8'd0;
         end else if (pm) begin
            hr_fix = hr + rtfu_pkg::HOURS_HALF_DAY;
         end
      end

      dec_in.ok      = hr_ok && hr_fix <= 8'd23 && mi <= 8'd59 && se <= 8'd59
                       && yr <= 8'd99 && ce <= 8'd99 && mo >= 8'd1 && mo <= 8'd12;
      dec_in.hour    = hr_fix[4:0];
      dec_in.minute  = mi[5:0];
      dec_in.second  = se[5:0];
      dec_in.year    = yr[6:0];
      dec_in.century = ce[6:0];
      dec_in.month   = mo[3:0];
      dec_in.day     = dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dec_ff <= dec_in;
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

// ===== rtl/rtfu_calendar.sv =====
// Second pipeline stage: leap year and day-of-month check, March-based year
// split, day of year and time of day. Depends on rtfu_pkg.
module rtfu_calendar (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rtfu_pkg::dec_type in_dec,
   output logic              out_valid,
   output rtfu_pkg::cal_type out_cal
);

   logic              valid_ff;
   rtfu_pkg::cal_type cal_ff;
   rtfu_pkg::cal_type cal_in;

   logic       leap, early, yr_zero;
   logic [4:0] mdays;

   always_comb begin
      // Century times 100 is a multiple of 4, so the year modulo 4 and 100
      // come straight from the two-digit year.
      yr_zero = in_dec.year == 7'd0;
      leap    = yr_zero ? (in_dec.century[1:0] == 2'd0) : (in_dec.year[1:0] == 2'd0);
      mdays   = rtfu_pkg::month_days(in_dec.month, leap);
      early   = in_dec.month <= 4'd2;

      cal_in.ok = in_dec.ok && in_dec.day >= 8'd1 && in_dec.day <= {3'b0, mdays};
      if (early && yr_zero) begin
         cal_in.cent_adj = $signed({1'b0, in_dec.century}) - 8'sd1;
         cal_in.year_adj = 7'd99;
      end else begin
         cal_in.cent_adj = $signed({1'b0, in_dec.century});
         cal_in.year_adj = early ? in_dec.year - 7'd1 : in_dec.year;
      end
      cal_in.day_of_year = rtfu_pkg::month_start(in_dec.month)
                           + {4'b0, in_dec.day[4:0]} - 9'd1;
      cal_in.time_of_day = 17'({12'b0, in_dec.hour} * 17'd3600)
                           + 17'({11'b0, in_dec.minute} * 17'd60)
                           + {11'b0, in_dec.second};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      cal_ff <= cal_in;
   end

   assign out_valid = valid_ff;
   assign out_cal   = cal_ff;

endmodule

// ===== rtl/rtfu_days.sv =====
// Third and fourth pipeline stages: century and year day products, then the
// signed day count since the epoch. Depends on rtfu_pkg.
module rtfu_days (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rtfu_pkg::cal_type in_cal,
   output logic              out_valid,
   output rtfu_pkg::day_type out_day
);

   logic               prod_valid_ff;
   logic               prod_ok_ff;
   logic signed [22:0] cent_days_ff, cent_days_in;
   logic [15:0]        year_days_ff, year_days_in;
   logic [16:0]        prod_tod_ff;
   logic signed [22:0] cent_ext;

   logic              valid_ff;
   rtfu_pkg::day_type day_ff;
   rtfu_pkg::day_type day_in;

   always_comb begin
      // A 400-year cycle holds 146097 days: 36524 per century plus one
      // every fourth century.
      cent_ext     = {{15{in_cal.cent_adj[7]}}, in_cal.cent_adj};
      cent_days_in = 23'(cent_ext * 23'sd36524) + (cent_ext >>> 2);
      year_days_in = 16'({9'b0, in_cal.year_adj} * 16'd365)
                     + {11'b0, in_cal.year_adj[6:2]} + {7'b0, in_cal.day_of_year};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
      end
      prod_ok_ff   <= in_cal.ok;
      cent_days_ff <= cent_days_in;
      year_days_ff <= year_days_in;
      prod_tod_ff  <= in_cal.time_of_day;
   end

   always_comb begin
      day_in.ok          = prod_ok_ff;
      day_in.days        = cent_days_ff + $signed({7'b0, year_days_ff})
                           - rtfu_pkg::EPOCH_SHIFT;
      day_in.time_of_day = prod_tod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prod_valid_ff;
      end
      day_ff <= day_in;
   end

   assign out_valid = valid_ff;
   assign out_day   = day_ff;

endmodule

// ===== rtl/rtfu_seconds.sv =====
// Final pipeline stage: days times 86400 plus time of day, zeroed when the
// snapshot was invalid, into the result register. Depends on rtfu_pkg.
module rtfu_seconds (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rtfu_pkg::day_type      in_day,
   output logic                   out_valid,
   output rtfu_pkg::rsp_word_type out_word
);

   logic                   valid_ff;
   rtfu_pkg::rsp_word_type word_ff;
   rtfu_pkg::rsp_word_type word_in;
   logic signed [39:0]     day_secs;

   always_comb begin
      day_secs = $signed({{17{in_day.days[22]}}, in_day.days}) * 40'sd86400;
      word_in.time_valid = in_day.ok;
      if (in_day.ok) begin
         word_in.unix_seconds = day_secs[38:0] + $signed({22'b0, in_day.time_of_day});
      end else begin
         word_in.unix_seconds = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/rtc_fields_to_unix_seconds.sv =====
// Top level of the RTC field to Unix seconds converter: configuration
// registers and the five-stage pipeline. Depends on rtfu_pkg and the rtfu_ stages.
//
// Each word on req_word is one snapshot of raw real-time-clock bytes. It is
// taken at any clock edge where start is high; busy is always low, so a new
// word may follow every cycle. Exactly one result word comes out for each
// snapshot, on rsp_word with rsp_valid high for a single cycle, and the words
// leave in the order the snapshots went in. The receiver cannot stall the
// pipeline and must take each result word in the cycle it appears. The five
// stages are: BCD decode and range checks, calendar split and day check, the
// century and year day products, the day count since 1970-01-01, and the
// multiply by 86400 into the output register. Any field out of calendar
// range gives time_valid low and zero seconds. The two mode registers are
// written through the csr_ port, which is always ready; they should only be
// changed while no snapshot is in flight, since a change applies to the word
// entering the first stage at that time.
module rtc_fields_to_unix_seconds (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rtfu_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output rtfu_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic                   csr_data
);

   logic hour_24_mode_ff;
   logic binary_mode_ff;

   logic              dec_valid;
   rtfu_pkg::dec_type dec;
   logic              cal_valid;
   rtfu_pkg::cal_type cal;
   logic              day_valid;
   rtfu_pkg::day_type day;

   // The pipeline never holds off input.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_24_mode_ff <= 1'b1;
         binary_mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rtfu_pkg::CSR_HOUR_24_MODE) begin
            hour_24_mode_ff <= csr_data;
         end
         if (csr_index == rtfu_pkg::CSR_BINARY_MODE) begin
            binary_mode_ff <= csr_data;
         end
      end
   end

   rtfu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .hour_24_mode (hour_24_mode_ff),
      .binary_mode  (binary_mode_ff),
      .in_valid     (start && !busy),
      .in_word      (req_word),
      .out_valid    (dec_valid),
      .out_dec      (dec)
   );

   rtfu_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_dec    (dec),
      .out_valid (cal_valid),
      .out_cal   (cal)
   );

   rtfu_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_valid),
      .in_cal    (cal),
      .out_valid (day_valid),
      .out_day   (day)
   );

   rtfu_seconds u_seconds (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_day    (day),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

// ===== sim/rtfu_snapshot_checker.sv =====
// Checker for the RTC field to Unix seconds converter: watches the snapshot,
// result and register channels, predicts each result word and compares it.
// Depends on rtfu_pkg for the word types and the register indexes.
module rtfu_snapshot_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  rtfu_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  rtfu_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic                   csr_data,
   output int unsigned            mismatches,
   output int unsigned            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECONDS_PER_DAY    = 86400;
   localparam int DAYS_PER_400_YEARS = 146097;
   // Days from 0000-03-01 to 1970-01-01.
   localparam int EPOCH_DAY_OFFSET   = 719468;

   logic                   hour_24;
   logic                   binary;
   rtfu_pkg::rsp_word_type expected_times[$];

   initial mismatches = 0;
   initial outstanding = 0;

   function automatic int decode_byte(input logic [7:0] b, input logic bin);
      return bin ? int'(b) : int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic rtfu_pkg::rsp_word_type convert_snapshot(
         input rtfu_pkg::req_word_type w, input logic h24, input logic bin);
      int                     hour, minute, second, yy, cc, month, day;
      int                     full_year, month_len, shifted, march_month;
      logic                   pm, ok, leap;
      longint                 day_count, total;
      rtfu_pkg::rsp_word_type r;
      pm     = w.hours_raw[7];
      hour   = decode_byte({1'b0, w.hours_raw[6:0]}, bin);
      minute = decode_byte(w.minutes_raw, bin);
      second = decode_byte(w.seconds_raw, bin);
      yy     = decode_byte(w.year_raw, bin);
      month  = decode_byte(w.month_raw, bin);
      day    = decode_byte(w.day_raw, bin);
      cc     = decode_byte(w.century_raw, bin);
      ok     = 1'b1;
      if (!h24) begin
         if (hour < 1 || hour > 12) ok = 1'b0;
         else if (hour == 12) hour = pm ? 12 : 0;
         else if (pm) hour += 12;
      end
      if (hour > 23 || minute > 59 || second > 59 || yy > 99 || cc > 99) ok = 1'b0;
      if (month < 1 || month > 12) ok = 1'b0;
      full_year = cc * 100 + yy;
      leap = ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
      if (ok) begin
         case (month)
            2:          month_len = leap ? 29 : 28;
            4, 6, 9, 11: month_len = 30;
            default:    month_len = 31;
         endcase
         if (day < 1 || day > month_len) ok = 1'b0;
      end
      r = '0;
      if (ok) begin
         // Shift by 400 years so that January and February of year 0 stay positive.
         shifted     = full_year + 400 - ((month <= 2) ? 1 : 0);
         march_month = (month + 9) % 12;
         day_count   = 365 * longint'(shifted) + shifted / 4 - shifted / 100 + shifted / 400
                     + (153 * march_month + 2) / 5 + day - 1
                     - EPOCH_DAY_OFFSET - DAYS_PER_400_YEARS;
         total       = day_count * SECONDS_PER_DAY + hour * 3600 + minute * 60 + second;
         r.unix_seconds = total[38:0];
         r.time_valid   = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rtfu_pkg::rsp_word_type want;
      if (reset) begin
         hour_24 = 1'b1;
         binary  = 1'b0;
         expected_times.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_times.size() == 0) begin
               $error("result word with no snapshot waiting: unix_seconds %0d time_valid %0b",
                      rsp_word.unix_seconds, rsp_word.time_valid);
               mismatches++;
            end else begin
               want = expected_times.pop_front();
               if (rsp_word.unix_seconds !== want.unix_seconds) begin
                  $error("unix_seconds: expected %0d, got %0d",
                         want.unix_seconds, rsp_word.unix_seconds);
                  mismatches++;
               end
               if (rsp_word.time_valid !== want.time_valid) begin
                  $error("time_valid: expected %0b, got %0b",
                         want.time_valid, rsp_word.time_valid);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            expected_times.push_back(convert_snapshot(req_word, hour_24, binary));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rtfu_pkg::CSR_HOUR_24_MODE: hour_24 = csr_data;
               rtfu_pkg::CSR_BINARY_MODE:  binary  = csr_data;
               default: ;
            endcase
         end
      end
      outstanding = expected_times.size();
   end

endmodule

// ===== sim/rtc_fields_to_unix_seconds_tb.sv =====
// Testbench top for the RTC field to Unix seconds converter: clock, reset,
// snapshot and register stimulus, and the verdict. Depends on rtfu_pkg, the
// block itself and rtfu_snapshot_checker.
module rtc_fields_to_unix_seconds_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 12;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 180;
   // The pipeline is five stages deep; the drain wait covers it with margin.
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 400000;
   // Register indexes that map to no register; writes to them must be ignored.
   localparam logic [1:0] CSR_RESERVED_LO = 2'd2;
   localparam logic [1:0] CSR_RESERVED_HI = 2'd3;

   // Every input of the block starts at a known value.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   rtfu_pkg::req_word_type req_word  = '0;
   logic                   csr_valid = 1'b0;
   logic [1:0]             csr_index = rtfu_pkg::CSR_HOUR_24_MODE;
   logic                   csr_data  = 1'b0;
   logic                   busy;
   logic                   rsp_valid;
   rtfu_pkg::rsp_word_type rsp_word;
   logic                   csr_ready;

   int unsigned  mismatches;
   int unsigned  outstanding;
   int unsigned  cycle_count = 0;
   // While nonzero, snapshot words go in back to back with no idle cycles.
   int unsigned  burst_left  = 0;

   always #(CLOCK_HALF) clock = ~clock;

   rtc_fields_to_unix_seconds dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rtfu_snapshot_checker snapshot_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Encodes a value of 0 to 99 as the block expects it: plain binary or two BCD digits.
   function automatic logic [7:0] field_byte(input int v, input logic bin);
      return bin ? 8'(v) : {4'(v / 10), 4'(v % 10)};
   endfunction

   // Presents one snapshot word and holds it until the block takes it. Start is
   // left high after acceptance so that the next word can follow in the very
   // next cycle; it is only lowered when an idle gap is chosen. Most gaps are
   // zero or short, a few are long, so gaps land on every pipeline stage.
   task automatic send_snapshot(input rtfu_pkg::req_word_type w);
      int unsigned roll;
      int unsigned gap;
      req_word <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      roll = $urandom_range(0, 99);
      if (burst_left != 0) begin
         burst_left--;
         gap = 0;
      end else if (roll < 60) begin
         gap = 0;
      end else if (roll < 92) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 40);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops the snapshot stream and waits until every expected result word has
   // come out, then lets the pipeline settle. The first edge makes sure the
   // checker has seen the last accepted word before its count is trusted.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Drives one register write and holds it until ready is seen. Valid stays
   // high so that writes can go back to back; the caller lowers it.
   task automatic write_csr(input logic [1:0] index, input logic data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Mode registers change only with the pipeline empty.
   task automatic set_modes(input logic h24, input logic bin);
      drain_pipeline();
      repeat ($urandom_range(0, 5)) @(posedge clock);
      write_csr(rtfu_pkg::CSR_HOUR_24_MODE, h24);
      write_csr(rtfu_pkg::CSR_BINARY_MODE, bin);
      csr_valid <= 1'b0;
   endtask

   initial begin
      rtfu_pkg::req_word_type w;
      logic [55:0]            raw;
      logic                   h24;
      logic                   bin;
      int                     hour;
      int                     field;
      int                     roll;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Writes to unmapped indexes must leave both modes at their reset values,
      // which the directed words right after them rely on.
      write_csr(CSR_RESERVED_LO, 1'b1);
      write_csr(CSR_RESERVED_HI, 1'b1);
      csr_valid <= 1'b0;

      // Directed words in the reset modes: 24-hour, BCD. Field order is hours,
      // minutes, seconds, year, month, day, century.
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19}); // the epoch
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}); // earliest
      send_snapshot('{8'h23, 8'h59, 8'h59, 8'h99, 8'h12, 8'h31, 8'h99}); // latest
      send_snapshot('{8'h12, 8'h34, 8'h56, 8'h00, 8'h02, 8'h29, 8'h20}); // leap day 2000
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h19}); // 1900 not leap
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h00}); // year 0 is leap
      send_snapshot('{8'h08, 8'h15, 8'h30, 8'h23, 8'h02, 8'h29, 8'h20}); // 2023 not leap
      send_snapshot('{8'h23, 8'h59, 8'h60, 8'h16, 8'h12, 8'h31, 8'h20}); // leap second
      send_snapshot('{8'h10, 8'h60, 8'h00, 8'h24, 8'h06, 8'h15, 8'h20}); // minute 60
      send_snapshot('{8'h24, 8'h00, 8'h00, 8'h24, 8'h06, 8'h15, 8'h20}); // hour 24
      // The PM flag is ignored in 24-hour mode.
      send_snapshot('{8'h95, 8'h30, 8'h00, 8'h24, 8'h06, 8'h15, 8'h20});
      // Bad BCD digits decode through tens*10 + units: 0x0F is 15 and 0x1A is 20.
      send_snapshot('{8'h08, 8'h0F, 8'h1A, 8'h24, 8'h06, 8'h15, 8'h20});
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h24, 8'h00, 8'h15, 8'h20}); // month 0
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h24, 8'h06, 8'h00, 8'h20}); // day 0
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h24, 8'h04, 8'h31, 8'h20}); // April 31
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0}); // century 100
      send_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});

      // 12-hour BCD: midnight is 12 AM, noon is 12 PM, hours 0 and 13 are invalid.
      set_modes(1'b0, 1'b0);
      send_snapshot('{8'h12, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});
      send_snapshot('{8'h92, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});
      send_snapshot('{8'h81, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});
      send_snapshot('{8'h00, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});
      send_snapshot('{8'h13, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});
      send_snapshot('{8'h80, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h19});

      // 24-hour binary: latest time, then a leap second.
      set_modes(1'b1, 1'b1);
      send_snapshot('{8'h17, 8'h3B, 8'h3B, 8'h63, 8'h0C, 8'h1F, 8'h63});
      send_snapshot('{8'h17, 8'h3B, 8'h3C, 8'h63, 8'h0C, 8'h1F, 8'h63});

      // 12-hour binary: noon and midnight.
      set_modes(1'b0, 1'b1);
      send_snapshot('{8'h8C, 8'h00, 8'h00, 8'h18, 8'h03, 8'h0A, 8'h14});
      send_snapshot('{8'h0C, 8'h00, 8'h00, 8'h18, 8'h03, 8'h0A, 8'h14});

      // Random phases walk through all four mode combinations twice. Most words
      // are well formed with random content, some have one field replaced by a
      // random byte, and the rest are random bytes throughout.
      for (int phase = 0; phase < PHASES; phase++) begin
         h24 = 1'(phase % 2);
         bin = 1'((phase / 2) % 2);
         set_modes(h24, bin);
         burst_left = (phase % 3 == 0) ? 60 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            hour          = $urandom_range(0, 23);
            w.minutes_raw = field_byte($urandom_range(0, 59), bin);
            w.seconds_raw = field_byte($urandom_range(0, 59), bin);
            w.year_raw    = field_byte($urandom_range(0, 99), bin);
            w.month_raw   = field_byte($urandom_range(1, 12), bin);
            w.day_raw     = field_byte(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31)
                                                                 : $urandom_range(1, 28), bin);
            // Mostly recent centuries, sometimes any of them.
            w.century_raw = field_byte(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                                   : $urandom_range(19, 21), bin);
            if (h24) begin
               w.hours_raw = field_byte(hour, bin)
                           | (($urandom_range(0, 3) == 0) ? rtfu_pkg::PM_FLAG_MASK : 8'h00);
            end else begin
               w.hours_raw = field_byte((hour % 12 == 0) ? 12 : hour % 12, bin)
                           | ((hour >= 12) ? rtfu_pkg::PM_FLAG_MASK : 8'h00);
            end
            roll = $urandom_range(0, 99);
            if (roll >= 85) begin
               raw = 56'({$urandom(), $urandom()});
               w   = raw;
            end else if (roll >= 70) begin
               raw   = w;
               field = $urandom_range(0, 6);
               raw[8 * field +: 8] = 8'($urandom());
               w     = raw;
            end
            send_snapshot(w);
         end
      end

      drain_pipeline();
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS rtc_fields_to_unix_seconds");
      end else begin
         $display("FAIL rtc_fields_to_unix_seconds");
      end
      $finish;
   end

   // Guard against a hung handshake: the slowest correct run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rtc_fields_to_unix_seconds");
         $finish;
      end
   end

endmodule
